// ===== hdl/pwrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrf_pkg: shared types and constants of the pulse-width RF frame transmitter
// Holds the phase encoding, register indexes, configuration and result structs,
// and the helpers that build the frame word and clamp durations.
// ----------------------------------------------------------------------------
package pwrf_pkg;

   // Frame length in bits and width of the tick counter.
   localparam int FRAME_BITS = 16;
   localparam int TICK_BITS  = 16;

   // Widths of the fields and registers.
   localparam int BYTE_W        = 8;
   localparam int PULSES_W      = 6;
   localparam int DUR_W         = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 3;
   localparam int BIT_INDEX_W   = $clog2(FRAME_BITS + 1);
   localparam int WORD_W        = 2 * BYTE_W;

   localparam logic [BYTE_W-1:0]    CHECK_MASK = 8'hAA;
   localparam logic [TICK_BITS-1:0] TICK_MAX   = '1;

   // Input command codes.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SEND = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_PREAMBLE_PULSES     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PREAMBLE_HALF_TICKS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAP_TICKS           = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_HIGH_TICKS     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_HIGH_TICKS      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_LOW_TICKS       = 3'd5;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_PRE_HIGH = 3'd1,
      PH_PRE_LOW  = 3'd2,
      PH_GAP      = 3'd3,
      PH_BIT_HIGH = 3'd4,
      PH_BIT_LOW  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [PULSES_W-1:0] preamble_pulses;
      logic [DUR_W-1:0]    preamble_half_ticks;
      logic [DUR_W-1:0]    gap_ticks;
      logic [DUR_W-1:0]    zero_high_ticks;
      logic [DUR_W-1:0]    one_high_ticks;
      logic [DUR_W-1:0]    bit_low_ticks;
   } cfg_type;

   typedef struct packed {
      logic tx_level;
      logic busy_res;
      logic accepted;
      logic frame_done;
   } rsp_type;

   // Frame word is the byte followed by its check byte, fitted to FRAME_BITS.
   function automatic logic [FRAME_BITS-1:0] frame_word(input logic [BYTE_W-1:0] data);
      logic [FRAME_BITS+WORD_W-1:0] wide;
      wide = (FRAME_BITS + WORD_W)'({data, data & CHECK_MASK});
      return wide[FRAME_BITS-1:0];
   endfunction

   // Clamp a duration register to the range of the tick counter.
   function automatic logic [TICK_BITS-1:0] sat_ticks(input logic [DUR_W-1:0] d);
      logic [TICK_BITS+DUR_W-1:0] wide;
      wide = (TICK_BITS + DUR_W)'(d);
      if (wide > (TICK_BITS + DUR_W)'(TICK_MAX)) begin
         return TICK_MAX;
      end
      return wide[TICK_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/pulse_width_rf_frame_transmitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_width_rf_frame_transmitter: pulse-width on-off-keyed frame transmitter
// Sends a byte and its check byte as preamble, optional gap, width-coded bits.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the req_ channel is either a time tick (req_cmd low) or a
// request to send req_data_byte (req_cmd high). Every item yields exactly one
// result item on the rsp_ channel: the line level, the busy flag, whether a
// send started a frame, and a done flag on the tick that ends the frame.
// A send that arrives while a frame is running is ignored and answered with
// accepted low. The csr_ port writes the six timing registers; it is meant to
// be used only while no frame is in progress and no result is pending.
// The result of an item is valid in the cycle after the item is accepted.
// Throughput is one item per cycle while the receiver keeps up, set by the
// single sequencer step between the state registers and the result register.
// When the receiver stalls, the result register holds its item and req_ready
// stays high only if that item is taken in the same cycle, so nothing is lost.
// Reset clears the sequencer to idle with the line low, loads the register
// defaults and empties the result register.
// ----------------------------------------------------------------------------
module pulse_width_rf_frame_transmitter (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Input items.
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_cmd,
   input  wire logic [pwrf_pkg::BYTE_W-1:0]      req_data_byte,
   // Result items.
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_tx_level,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_accepted,
   output logic                                  rsp_frame_done,
   // Configuration writes.
   input  wire logic                             csr_we,
   input  wire logic [pwrf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pwrf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pwrf_pkg::*;

   cfg_type cfg;
   rsp_type step_result;
   rsp_type rsp_data;
   logic    space;
   logic    item_accept;

   // An item is taken whenever the result register has room for its result.
   assign req_ready   = space;
   assign item_accept = req_valid && space;

   pwrf_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The sequencer advances one step per accepted item.
   pwrf_frame_fsm u_frame_fsm (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .item_valid     (item_accept),
      .item_cmd       (req_cmd),
      .item_data_byte (req_data_byte),
      .result         (step_result)
   );

   pwrf_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (item_accept),
      .load_data (step_result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tx_level   = rsp_data.tx_level;
   assign rsp_busy_res   = rsp_data.busy_res;
   assign rsp_accepted   = rsp_data.accepted;
   assign rsp_frame_done = rsp_data.frame_done;

endmodule
`default_nettype wire

// ===== hdl/pwrf_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrf_cfg_regs: timing configuration registers
// Six write-only registers loaded through a plain indexed write port.
// ----------------------------------------------------------------------------
module pwrf_cfg_regs (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [pwrf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pwrf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output pwrf_pkg::cfg_type                     cfg
);
   import pwrf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PREAMBLE_PULSES:     cfg_in.preamble_pulses     = csr_wdata[PULSES_W-1:0];
            REG_PREAMBLE_HALF_TICKS: cfg_in.preamble_half_ticks = csr_wdata[DUR_W-1:0];
            REG_GAP_TICKS:           cfg_in.gap_ticks           = csr_wdata[DUR_W-1:0];
            REG_ZERO_HIGH_TICKS:     cfg_in.zero_high_ticks     = csr_wdata[DUR_W-1:0];
            REG_ONE_HIGH_TICKS:      cfg_in.one_high_ticks      = csr_wdata[DUR_W-1:0];
            REG_BIT_LOW_TICKS:       cfg_in.bit_low_ticks       = csr_wdata[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_pulses     <= PULSES_W'(20);
         cfg_ff.preamble_half_ticks <= DUR_W'(5);
         cfg_ff.gap_ticks           <= DUR_W'(1);
         cfg_ff.zero_high_ticks     <= DUR_W'(10);
         cfg_ff.one_high_ticks      <= DUR_W'(20);
         cfg_ff.bit_low_ticks       <= DUR_W'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hdl/pwrf_frame_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrf_frame_fsm: frame sequencer
// Holds the phase, counters and frame shift register, and advances them by one
// step for every accepted item. Produces the result of that item.
// ----------------------------------------------------------------------------
module pwrf_frame_fsm (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  pwrf_pkg::cfg_type                cfg,
   input  wire logic                        item_valid,
   input  wire logic                        item_cmd,
   input  wire logic [pwrf_pkg::BYTE_W-1:0] item_data_byte,
   output pwrf_pkg::rsp_type                result
);
   import pwrf_pkg::*;

   phase_type                phase_ff,       phase_in;
   logic [PULSES_W-1:0]      pulse_count_ff, pulse_count_in;
   logic [BIT_INDEX_W-1:0]   bit_index_ff,   bit_index_in;
   logic [TICK_BITS-1:0]     tick_count_ff,  tick_count_in;
   logic [FRAME_BITS-1:0]    frame_shift_ff, frame_shift_in;
   logic                     line_level_ff,  line_level_in;

   logic [DUR_W-1:0]         dur_raw;
   logic [TICK_BITS-1:0]     tick_inc;
   logic                     tick_end;
   logic [PULSES_W-1:0]      pulse_inc;
   logic [BIT_INDEX_W-1:0]   bit_inc;
   logic                     acc;
   logic                     done;

   // Duration of the current phase; a data bit's high time follows its value.
   always_comb begin
      unique case (phase_ff)
         PH_PRE_HIGH, PH_PRE_LOW: dur_raw = cfg.preamble_half_ticks;
         PH_GAP:                  dur_raw = cfg.gap_ticks;
         PH_BIT_HIGH:             dur_raw = frame_shift_ff[FRAME_BITS-1] ?
                                            cfg.one_high_ticks : cfg.zero_high_ticks;
         PH_BIT_LOW:              dur_raw = cfg.bit_low_ticks;
         default:                 dur_raw = '0;
      endcase
   end

   assign tick_inc  = tick_count_ff + TICK_BITS'(1);
   assign tick_end  = (tick_inc >= sat_ticks(dur_raw));
   assign pulse_inc = pulse_count_ff + PULSES_W'(1);
   assign bit_inc   = bit_index_ff + BIT_INDEX_W'(1);

   always_comb begin
      phase_in       = phase_ff;
      pulse_count_in = pulse_count_ff;
      bit_index_in   = bit_index_ff;
      tick_count_in  = tick_count_ff;
      frame_shift_in = frame_shift_ff;
      line_level_in  = line_level_ff;
      acc            = 1'b0;
      done           = 1'b0;

      if (item_valid) begin
         if (item_cmd == CMD_SEND) begin
            if (phase_ff == PH_IDLE) begin
               frame_shift_in = frame_word(item_data_byte);
               phase_in       = PH_PRE_HIGH;
               line_level_in  = 1'b1;
               pulse_count_in = '0;
               bit_index_in   = '0;
               tick_count_in  = '0;
               acc            = 1'b1;
            end
         end else begin
            if (phase_ff != PH_IDLE) begin
               tick_count_in = tick_end ? '0 : tick_inc;
            end
            unique case (phase_ff)
               PH_IDLE: ;
               PH_PRE_HIGH: begin
                  if (tick_end) begin
                     phase_in      = PH_PRE_LOW;
                     line_level_in = 1'b0;
                  end
               end
               PH_PRE_LOW: begin
                  if (tick_end) begin
                     pulse_count_in = pulse_inc;
                     if (pulse_inc >= cfg.preamble_pulses) begin
                        if (cfg.gap_ticks == '0) begin
                           phase_in      = PH_BIT_HIGH;
                           line_level_in = 1'b1;
                        end else begin
                           phase_in      = PH_GAP;
                           line_level_in = 1'b0;
                        end
                     end else begin
                        phase_in      = PH_PRE_HIGH;
                        line_level_in = 1'b1;
                     end
                  end
               end
               PH_GAP: begin
                  if (tick_end) begin
                     phase_in      = PH_BIT_HIGH;
                     line_level_in = 1'b1;
                  end
               end
               PH_BIT_HIGH: begin
                  if (tick_end) begin
                     phase_in      = PH_BIT_LOW;
                     line_level_in = 1'b0;
                  end
               end
               PH_BIT_LOW: begin
                  if (tick_end) begin
                     frame_shift_in = {frame_shift_ff[FRAME_BITS-2:0], 1'b0};
                     if (bit_inc >= BIT_INDEX_W'(FRAME_BITS)) begin
                        phase_in       = PH_IDLE;
                        line_level_in  = 1'b0;
                        bit_index_in   = '0;
                        pulse_count_in = '0;
                        done           = 1'b1;
                     end else begin
                        bit_index_in  = bit_inc;
                        phase_in      = PH_BIT_HIGH;
                        line_level_in = 1'b1;
                     end
                  end
               end
               default: begin
                  phase_in      = PH_IDLE;
                  line_level_in = 1'b0;
               end
            endcase
         end
      end

      result.tx_level   = line_level_in;
      result.busy_res   = (phase_in != PH_IDLE);
      result.accepted   = acc;
      result.frame_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         pulse_count_ff <= '0;
         bit_index_ff   <= '0;
         tick_count_ff  <= '0;
         frame_shift_ff <= '0;
         line_level_ff  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         pulse_count_ff <= pulse_count_in;
         bit_index_ff   <= bit_index_in;
         tick_count_ff  <= tick_count_in;
         frame_shift_ff <= frame_shift_in;
         line_level_ff  <= line_level_in;
      end
   end

   // The carrier is only on during a preamble high half or a data bit high.
   a_line_high_phase: assert property (@(posedge clock) disable iff (reset)
      line_level_ff |-> (phase_ff == PH_PRE_HIGH || phase_ff == PH_BIT_HIGH))
      else $error("line high outside a high phase");

   // A send taken while idle starts the preamble with the carrier on.
   a_send_starts: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item_cmd == CMD_SEND && phase_ff == PH_IDLE)
      |=> (phase_ff == PH_PRE_HIGH && line_level_ff && tick_count_ff == '0))
      else $error("send from idle did not start a frame");

   // A finished frame leaves the sequencer idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (item_valid && result.frame_done) |=> (phase_ff == PH_IDLE && !line_level_ff))
      else $error("frame done but sequencer not idle");

   // The stored bit index always points inside the frame.
   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff < BIT_INDEX_W'(FRAME_BITS))
      else $error("bit index past end of frame");

endmodule
`default_nettype wire

// ===== hdl/pwrf_rsp_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrf_rsp_reg: result output register
// Holds one result item until the receiver takes it; a new result can be
// loaded in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module pwrf_rsp_reg (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  pwrf_pkg::rsp_type  load_data,
   output logic               space,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output pwrf_pkg::rsp_type  rsp_data
);
   import pwrf_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire
